>>> rtl/u2da_pkg.sv
// Shared constants, types and state encodings for the unsigned to decimal ASCII unit.
// Used by every module of the block; depends on nothing else.
package u2da_pkg;

  // Width of the binary input value.
  localparam int VALUE_WIDTH = 32;

  // Input bits folded into the BCD digits per conversion cycle.
  localparam int DD_BITS    = 4;
  localparam int STEPS      = (VALUE_WIDTH + DD_BITS - 1) / DD_BITS;
  localparam int PAD_WIDTH  = STEPS * DD_BITS;
  localparam int STEP_CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Decimal digits of the largest input value (floor(W * log10(2)) + 1).
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
  localparam int IDX_W      = $clog2(DEC_DIGITS);

  // Queue between the converter and the character sender.
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int CHAR_WIDTH = 6;
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = CHAR_WIDTH'(57);

  typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

  // One converted number: its BCD digits and how many of them are significant.
  typedef struct packed {
    digits_t           digits;
    logic [NDIG_W-1:0] ndig;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_DONE
  } front_state_t;

endpackage

>>> rtl/unsigned_to_decimal_ascii_unit.sv
// Top level of the unsigned to decimal ASCII unit: converter, queue and character sender.
// Depends on u2da_pkg, u2da_front, u2da_queue and u2da_back.
//
// The unit takes an unsigned VALUE_WIDTH-bit number per request on the input queue
// interface (in_push/in_full) and returns its decimal text as ASCII digit characters on the
// result queue interface (out_empty/out_pop), one request per character, most significant
// digit first, without leading zeros. A zero input yields the single character '0'. The
// final character of each number carries out_last. The converter uses shift and add-3 over
// DD_BITS input bits per cycle, and in_full stays high while it converts and until the
// result enters the queue. A two-entry queue of finished numbers separates it from the
// character sender, which shows one character per cycle while the consumer pops and the
// queue is not empty. With a consumer that always pops, the up to 10 characters of a 32-bit
// value follow at one per cycle; a slow consumer only fills the queue before it holds off
// the input side. There is no state between numbers and nothing to configure.
module unsigned_to_decimal_ascii_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [u2da_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [u2da_pkg::CHAR_WIDTH-1:0]  out_digit_char,
  output logic                             out_last
);

  // Converter to queue.
  logic             fq_push;
  logic             fq_full;
  u2da_pkg::entry_t fq_entry;

  // Queue to sender.
  logic             qb_pop;
  logic             qb_empty;
  u2da_pkg::entry_t qb_entry;

  u2da_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .q_push   (fq_push),
    .q_full   (fq_full),
    .q_entry  (fq_entry)
  );

  u2da_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .wr_entry (fq_entry),
    .full     (fq_full),
    .pop      (qb_pop),
    .rd_entry (qb_entry),
    .empty    (qb_empty)
  );

  u2da_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (qb_empty),
    .q_entry        (qb_entry),
    .q_pop          (qb_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  // A request taken on the input side keeps the converter busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("input side ready right after accepting a value");

endmodule

>>> rtl/u2da_front.sv
// Converter front end: accepts a binary value and turns it into BCD digits by shift and
// add-3, DD_BITS input bits per cycle. Depends on u2da_pkg.
module u2da_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [u2da_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             q_push,
  input  logic                             q_full,
  output u2da_pkg::entry_t                 q_entry
);

  u2da_pkg::front_state_t state_r, state_nxt;

  logic [u2da_pkg::PAD_WIDTH-1:0] sh_r;
  u2da_pkg::digits_t              bcd_r;
  logic [u2da_pkg::STEP_CW-1:0]   cnt_r;

  // Folds DD_BITS bits, most significant first, into the BCD accumulator.
  function automatic u2da_pkg::digits_t dd_step(u2da_pkg::digits_t d_in,
                                                logic [u2da_pkg::DD_BITS-1:0] bits);
    u2da_pkg::digits_t d;
    logic [u2da_pkg::DEC_DIGITS*4-1:0] flat;
    d = d_in;
    for (int b = u2da_pkg::DD_BITS - 1; b >= 0; b--) begin
      for (int k = 0; k < u2da_pkg::DEC_DIGITS; k++) begin
        if (d[k] >= 4'd5) begin
          d[k] = d[k] + 4'd3;
        end
      end
      flat = d;
      flat = {flat[u2da_pkg::DEC_DIGITS*4-2:0], bits[b]};
      d    = flat;
    end
    return d;
  endfunction

  // Number of significant digits; a zero value still has one.
  function automatic logic [u2da_pkg::NDIG_W-1:0] ndig_of(u2da_pkg::digits_t d);
    logic [u2da_pkg::NDIG_W-1:0] n;
    n = u2da_pkg::NDIG_W'(1);
    for (int k = 0; k < u2da_pkg::DEC_DIGITS; k++) begin
      if (d[k] != 4'd0) begin
        n = u2da_pkg::NDIG_W'(k + 1);
      end
    end
    return n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      u2da_pkg::F_IDLE: begin
        if (in_push) state_nxt = u2da_pkg::F_CONV;
      end
      u2da_pkg::F_CONV: begin
        if (cnt_r == '0) state_nxt = u2da_pkg::F_DONE;
      end
      u2da_pkg::F_DONE: begin
        if (!q_full) state_nxt = u2da_pkg::F_IDLE;
      end
      default: state_nxt = u2da_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    unique case (state_r)
      u2da_pkg::F_IDLE: in_full = 1'b0;
      u2da_pkg::F_CONV: in_full = 1'b1;
      u2da_pkg::F_DONE: q_push  = !q_full;
      default:          in_full = 1'b1;
    endcase
  end

  assign q_entry.digits = bcd_r;
  assign q_entry.ndig   = ndig_of(bcd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u2da_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == u2da_pkg::F_IDLE) begin
      sh_r  <= u2da_pkg::PAD_WIDTH'(in_value);
      bcd_r <= '0;
      cnt_r <= u2da_pkg::STEP_CW'(u2da_pkg::STEPS - 1);
    end else if (state_r == u2da_pkg::F_CONV) begin
      bcd_r <= dd_step(bcd_r, sh_r[u2da_pkg::PAD_WIDTH-1 -: u2da_pkg::DD_BITS]);
      sh_r  <= sh_r << u2da_pkg::DD_BITS;
      cnt_r <= cnt_r - u2da_pkg::STEP_CW'(1);
    end
  end

  a_conv_exits_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == u2da_pkg::F_CONV && cnt_r == '0 |=> state_r == u2da_pkg::F_DONE)
    else $error("converter did not finish after its last step");

endmodule

>>> rtl/u2da_queue.sv
// Short queue of converted numbers between the converter and the character sender.
// Depends on u2da_pkg for its depth and entry type.
module u2da_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u2da_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output u2da_pkg::entry_t rd_entry,
  output logic             empty
);

  u2da_pkg::entry_t mem_r [u2da_pkg::QDEPTH];

  logic [u2da_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [u2da_pkg::QCNT_W-1:0] count_r;
  logic                        do_push, do_pop;

  assign full     = (count_r == u2da_pkg::QCNT_W'(u2da_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == u2da_pkg::QPTR_W'(u2da_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_r + u2da_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == u2da_pkg::QPTR_W'(u2da_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_r + u2da_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + u2da_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - u2da_pkg::QCNT_W'(1);
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= u2da_pkg::QCNT_W'(u2da_pkg::QDEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

>>> rtl/u2da_back.sv
// Character sender: takes converted numbers from the queue and presents their digits as
// ASCII, most significant first, one per pop. Depends on u2da_pkg.
module u2da_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  u2da_pkg::entry_t                q_entry,
  output logic                            q_pop,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [u2da_pkg::CHAR_WIDTH-1:0] out_digit_char,
  output logic                            out_last
);

  logic                       valid_r, valid_nxt;
  u2da_pkg::digits_t          digits_r;
  logic [u2da_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       load, taken;

  assign taken = out_pop && valid_r;
  // Refill when nothing is shown or the last digit of the current number leaves.
  assign load  = !q_empty && (!valid_r || (taken && idx_r == '0));
  assign q_pop = load;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = u2da_pkg::IDX_W'(q_entry.ndig - u2da_pkg::NDIG_W'(1));
    end else if (taken) begin
      if (idx_r == '0) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - u2da_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load) begin
      digits_r <= q_entry.digits;
    end
  end

  assign out_empty      = !valid_r;
  assign out_digit_char = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_WIDTH'(digits_r[idx_r]);
  assign out_last       = (idx_r == '0);

  a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> out_digit_char >= u2da_pkg::ASCII_ZERO &&
                out_digit_char <= u2da_pkg::ASCII_NINE)
    else $error("sender presents a character that is not a decimal digit");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r < u2da_pkg::IDX_W'(u2da_pkg::DEC_DIGITS))
    else $error("digit index outside the converted number");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for unsigned_to_decimal_ascii_unit: directed table, then random values.
// Depends on u2da_pkg and the unit's RTL; predicts every digit character in the bench itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with neither a value nor a character accepted before the run is declared hung.
  // The slowest correct gap is a conversion plus short random stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  // Random values after the directed table.
  localparam int RANDOM_VALUES  = 358;
  // Random values with index from STEADY_FIRST up to, not including, STEADY_LAST run with neither side ever idling.
  localparam int STEADY_FIRST   = 150;
  localparam int STEADY_LAST    = 230;
  // Chance in a hundred that a side idles in a given cycle.
  localparam int IDLE_PCT       = 26;
  // Cycles to wait after the last expected character, to catch stray extra output.
  localparam int DRAIN_CYCLES   = 20;

  // One expected character on the result side.
  typedef struct packed {
    logic [u2da_pkg::CHAR_WIDTH-1:0] code;
    logic                            last;
  } digit_rec_t;

  // One row of the directed table. An empty text means the bench predicts the digits.
  typedef struct {
    logic [u2da_pkg::VALUE_WIDTH-1:0] value;
    string                            text;
  } directed_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_push;
  logic                             in_full;
  logic [u2da_pkg::VALUE_WIDTH-1:0] in_value;
  logic                             out_empty;
  logic                             out_pop;
  logic [u2da_pkg::CHAR_WIDTH-1:0]  out_digit_char;
  logic                             out_last;

  digit_rec_t pending_chars[$];
  int         mismatch_count = 0;
  int         quiet_cycles   = 0;
  bit         steady         = 0;

  unsigned_to_decimal_ascii_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_value      (in_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  // The directed part: zero, the full-scale value, the single-bit extremes, and the digit-count
  // boundaries up to four digits and from eight to ten. Rows whose text is obvious carry it;
  // the alternating bit patterns, 4294967294 and 1000000007 are left to the predictor.
  directed_row_t directed_table[22] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd99,         "99"},
    '{32'd100,        "100"},
    '{32'd999,        "999"},
    '{32'd1000,       "1000"},
    '{32'd65535,      "65535"},
    '{32'd99999999,   "99999999"},
    '{32'd100000000,  "100000000"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'd2147483647, "2147483647"},
    '{32'd2147483648, "2147483648"},
    '{32'd4294967295, "4294967295"},
    '{32'd0,          "0"},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd4294967294, ""},
    '{32'd1000000007, ""},
    '{32'd7,          "7"}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Prints one line for a mismatch and counts it; the run carries on regardless.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Predictor: peel decimal digits off the value least significant first, then queue them
  // most significant first. A zero value still yields one digit, the character '0'. Only
  // the final digit of the number carries the last flag.
  task automatic queue_decimal_chars(input logic [u2da_pkg::VALUE_WIDTH-1:0] value);
    logic [3:0]                       rev_digits[u2da_pkg::DEC_DIGITS];
    logic [u2da_pkg::VALUE_WIDTH-1:0] rest;
    int                               count;
    digit_rec_t                       rec;
    rest  = value;
    count = 0;
    do begin
      rev_digits[count] = 4'(rest % 10);
      rest = rest / 10;
      count++;
    end while (rest != 0 && count < u2da_pkg::DEC_DIGITS);
    for (int k = 0; k < count; k++) begin
      rec.code = u2da_pkg::ASCII_ZERO +
                 u2da_pkg::CHAR_WIDTH'(rev_digits[count - 1 - k]);
      rec.last = (k == count - 1);
      pending_chars.push_back(rec);
    end
  endtask

  // Queues the characters of a typed-in decimal string; only the six low bits of each
  // ASCII code reach the result port.
  task automatic queue_typed_text(input string text);
    digit_rec_t rec;
    byte        ch;
    for (int k = 0; k < text.len(); k++) begin
      ch       = text[k];
      rec.code = ch[u2da_pkg::CHAR_WIDTH-1:0];
      rec.last = (k == text.len() - 1);
      pending_chars.push_back(rec);
    end
  endtask

  // Offers one value from a falling edge on and returns at the falling edge after the
  // rising edge that accepts it. Unless steady, push idles at random, so push may drop
  // while the value waits; it only ever changes at a falling edge. The expectation is
  // queued at the accepting edge; its characters cannot appear before the next edge.
  task automatic send_value(input logic [u2da_pkg::VALUE_WIDTH-1:0] value,
                            input string text);
    bit offer;
    bit taken;
    taken    = 1'b0;
    in_value <= value;
    while (!taken) begin
      offer   = steady || ($urandom_range(99) >= IDLE_PCT);
      in_push <= offer;
      @(posedge clk);
      taken = offer && !in_full;
      if (!taken) begin
        @(negedge clk);
      end
    end
    if (text.len() != 0) begin
      queue_typed_text(text);
    end else begin
      queue_decimal_chars(value);
    end
    @(negedge clk);
  endtask

  // Random values spread over every decimal length: full 32-bit words, words cut down to a
  // random number of bits, and powers of ten with their neighbors just below and above.
  function automatic logic [u2da_pkg::VALUE_WIDTH-1:0] pick_random_value();
    longint unsigned pow10;
    int              kind;
    kind = $urandom_range(9);
    if (kind < 3) begin
      return $urandom;
    end else if (kind < 7) begin
      return $urandom >> $urandom_range(u2da_pkg::VALUE_WIDTH - 1);
    end else begin
      pow10 = 1;
      repeat ($urandom_range(9)) pow10 = pow10 * 10;
      case ($urandom_range(2))
        0:       return u2da_pkg::VALUE_WIDTH'(pow10 - 1);
        1:       return u2da_pkg::VALUE_WIDTH'(pow10);
        default: return u2da_pkg::VALUE_WIDTH'(pow10 + 1);
      endcase
    end
  endfunction

  // Consumer: pops at random from the falling edge on, and always during the steady stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every character popped is compared, field by field, with the oldest one expected.
  always @(posedge clk) begin
    digit_rec_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%0h last=%0b",
                                  out_digit_char, out_last));
      end else begin
        want = pending_chars.pop_front();
        if (out_digit_char !== want.code) begin
          report_mismatch($sformatf("digit_char 0x%0h, expected 0x%0h",
                                    out_digit_char, want.code));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b (digit 0x%0h)",
                                    out_last, want.last, want.code));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_push  = 1'b0;
    in_value = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table first, then the random part.
    foreach (directed_table[i]) begin
      send_value(directed_table[i].value, directed_table[i].text);
    end
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      steady = (n >= STEADY_FIRST && n < STEADY_LAST);
      send_value(pick_random_value(), "");
    end
    steady = 1'b0;
    in_push <= 1'b0;

    // Let every expected character arrive, then watch a little longer for strays.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
